// ----- rtl/core/pltq_pkg.sv -----
// Shared types and constants for the pc/line delta table query core.
// No dependencies; imported by every module of the core but pltq_fifo.
`default_nettype none

package pltq_pkg;

    localparam logic [1:0] MODE_STACK  = 2'd0;
    localparam logic [1:0] MODE_LINE   = 2'd1;
    localparam logic [1:0] MODE_ADDR   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] CFG_QUERY_MODE = 3'd0;
    localparam logic [2:0] CFG_TEXT_START = 3'd1;
    localparam logic [2:0] CFG_TEXT_END   = 3'd2;
    localparam logic [2:0] CFG_PC_QUANTUM = 3'd3;
    localparam logic [2:0] CFG_QUERY_PC   = 3'd4;
    localparam logic [2:0] CFG_QUERY_LINE = 3'd5;
    localparam logic [2:0] CFG_BASE_PC    = 3'd6;
    localparam logic [2:0] CFG_END_PC     = 3'd7;

    localparam logic [31:0] GAP_INIT      = 32'h7fff_ffff;
    localparam logic [31:0] NOT_FOUND     = 32'hffff_ffff;
    localparam logic [7:0]  ADD_LIMIT     = 8'd65;
    localparam logic [7:0]  SUB_LIMIT     = 8'd129;
    localparam logic [7:0]  SUB_BIAS      = 8'd64;
    localparam logic [2:0]  ESC_LEN       = 3'd4;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       first_of_table;
        logic       last_of_table;
    } item_t;

    typedef struct packed {
        logic signed [31:0] answer_value;
        logic               answer_found;
    } result_t;

    typedef struct packed {
        logic [1:0]  query_mode;
        logic [31:0] text_start;
        logic [31:0] text_end;
        logic [4:0]  pc_quantum;
        logic [31:0] query_pc;
        logic [31:0] query_line;
        logic [31:0] base_pc;
        logic [31:0] end_pc;
    } cfg_t;

    typedef struct packed {
        logic              first;
        logic              last;
        logic              zero_op;
        logic [7:0]        raw_byte;
        logic [11:0]       pc_step;
        logic signed [9:0] value_step;
        logic [31:0]       start_pc;
    } op_t;

endpackage

`default_nettype wire

// ----- rtl/core/pltq_fifo.sv -----
// Small synchronous queue used between front and back and on the result side.
// No dependencies.
`default_nettype none

module pltq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("write into full queue");
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && empty))
        else $error("read from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pltq_front.sv -----
// Front end: takes table bytes and decodes pc and value steps for the back end.
// Depends on pltq_pkg.
`default_nettype none

module pltq_front
    import pltq_pkg::*;
(
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output logic       op_push,
    output op_t        op,
    input  wire logic  op_full
);

    logic [7:0]  b;
    logic [6:0]  adv;
    logic [6:0]  mag;
    logic [8:0]  scaled;

    assign b       = item.table_byte;
    assign full    = op_full;
    assign op_push = push && !op_full;

    always_comb
    begin
        adv    = (b >= SUB_LIMIT) ? b[6:0] : 7'd1;
        mag    = (b < ADD_LIMIT) ? b[6:0] : 7'(b - SUB_BIAS);
        scaled = (cfg.query_mode == MODE_STACK) ? {mag, 2'b00} : {2'b00, mag};

        op.first    = item.first_of_table;
        op.last     = item.last_of_table;
        op.zero_op  = (b == 8'd0);
        op.raw_byte = b;
        op.pc_step  = 12'(cfg.pc_quantum) * 12'(adv);
        op.start_pc = cfg.text_start - 32'(cfg.pc_quantum);
        if (b >= SUB_LIMIT)
        begin
            op.value_step = '0;
        end
        else if (b < ADD_LIMIT)
        begin
            op.value_step = $signed({1'b0, scaled});
        end
        else
        begin
            op.value_step = -$signed({1'b0, scaled});
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pltq_back.sv -----
// Back end: walks the decoded table, tracks pc, value and best match, emits answers.
// Depends on pltq_pkg.
`default_nettype none

module pltq_back
    import pltq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire op_t  op,
    input  wire logic op_empty,
    output logic      take,
    input  wire logic res_full,
    output logic      res_push,
    output result_t   res
);

    logic [31:0] walk_pc_reg, walk_pc_next;
    logic [31:0] value_reg, value_next;
    logic [2:0]  esc_left_reg, esc_left_next;
    logic [23:0] esc_bytes_reg, esc_bytes_next;
    logic        finished_reg, finished_next;
    logic [31:0] best_gap_reg, best_gap_next;
    logic [31:0] best_addr_reg, best_addr_next;
    logic        reached_reg, reached_next;

    logic [31:0] cur_pc, cur_val, cur_gap, cur_addr, gap;
    logic [2:0]  cur_left;
    logic [23:0] cur_bytes;
    logic        cur_reached, active, pc_mode, halt;

    assign pc_mode = (cfg.query_mode == MODE_STACK) || (cfg.query_mode == MODE_LINE);
    assign take    = !op_empty && !res_full;
    assign active  = take && (op.first || !finished_reg);

    always_comb
    begin
        cur_pc      = op.first ? op.start_pc : walk_pc_reg;
        cur_val     = op.first ? '0 : value_reg;
        cur_left    = op.first ? '0 : esc_left_reg;
        cur_bytes   = op.first ? '0 : esc_bytes_reg;
        cur_gap     = op.first ? GAP_INIT : best_gap_reg;
        cur_addr    = op.first ? NOT_FOUND : best_addr_reg;
        cur_reached = op.first ? 1'b0 : reached_reg;
        gap = (cur_val >= cfg.query_line) ? cur_val - cfg.query_line
                                          : cfg.query_line - cur_val;

        walk_pc_next   = walk_pc_reg;
        value_next     = value_reg;
        esc_left_next  = esc_left_reg;
        esc_bytes_next = esc_bytes_reg;
        finished_next  = finished_reg;
        best_gap_next  = best_gap_reg;
        best_addr_next = best_addr_reg;
        reached_next   = reached_reg;
        halt           = 1'b0;
        res_push           = 1'b0;
        res.answer_value   = $signed(NOT_FOUND);
        res.answer_found   = 1'b0;

        if (active)
        begin
            walk_pc_next   = cur_pc;
            value_next     = cur_val;
            esc_left_next  = cur_left;
            esc_bytes_next = cur_bytes;
            best_gap_next  = cur_gap;
            best_addr_next = cur_addr;
            reached_next   = cur_reached;

            if (op.first && pc_mode &&
                (cfg.query_pc < op.start_pc || cfg.query_pc > cfg.text_end))
            begin
                res_push = 1'b1;
            end
            else if (op.first && cfg.query_mode == MODE_ADDR && cfg.query_line == '0)
            begin
                res_push = 1'b1;
            end
            else if (cfg.query_mode == MODE_UNUSED)
            begin
                res_push = 1'b1;
            end
            else if (cur_left != '0)
            begin
                esc_left_next = cur_left - 1'b1;
                if (cur_left == 3'd1)
                begin
                    value_next   = cur_val + {cur_bytes, op.raw_byte};
                    walk_pc_next = cur_pc + 32'(cfg.pc_quantum);
                end
                else
                begin
                    esc_bytes_next = {cur_bytes[15:0], op.raw_byte};
                end
            end
            else
            begin
                if (pc_mode)
                begin
                    if (cur_pc >= cfg.query_pc)
                    begin
                        halt             = 1'b1;
                        res_push         = 1'b1;
                        res.answer_value = $signed(cur_val);
                        res.answer_found = 1'b1;
                    end
                end
                else if (cfg.end_pc != '0 && cur_pc >= cfg.end_pc)
                begin
                    halt             = 1'b1;
                    res_push         = 1'b1;
                    res.answer_value = cur_reached ? $signed(cur_addr) : $signed(NOT_FOUND);
                    res.answer_found = cur_reached;
                end
                else if (cur_pc >= cfg.base_pc)
                begin
                    if (cur_val >= cfg.query_line)
                    begin
                        reached_next = 1'b1;
                    end
                    if ($signed(gap) < $signed(cur_gap))
                    begin
                        best_gap_next  = gap;
                        best_addr_next = cur_pc;
                    end
                end

                if (!halt)
                begin
                    if (op.zero_op)
                    begin
                        esc_left_next  = ESC_LEN;
                        esc_bytes_next = '0;
                    end
                    else
                    begin
                        value_next   = cur_val + {{22{op.value_step[9]}}, op.value_step};
                        walk_pc_next = cur_pc + 32'(op.pc_step);
                    end
                end
            end

            if (!res_push && op.last)
            begin
                res_push = 1'b1;
                if (esc_left_next == '0 && !pc_mode)
                begin
                    res.answer_value = reached_next ? $signed(best_addr_next)
                                                    : $signed(NOT_FOUND);
                    res.answer_found = reached_next;
                end
            end

            finished_next = res_push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_pc_reg   <= '0;
            value_reg     <= '0;
            esc_left_reg  <= '0;
            esc_bytes_reg <= '0;
            finished_reg  <= 1'b1;
            best_gap_reg  <= GAP_INIT;
            best_addr_reg <= NOT_FOUND;
            reached_reg   <= 1'b0;
        end
        else
        begin
            walk_pc_reg   <= walk_pc_next;
            value_reg     <= value_next;
            esc_left_reg  <= esc_left_next;
            esc_bytes_reg <= esc_bytes_next;
            finished_reg  <= finished_next;
            best_gap_reg  <= best_gap_next;
            best_addr_reg <= best_addr_next;
            reached_reg   <= reached_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_esc_bound : assert property (@(posedge clk) disable iff (!rst_n)
        esc_left_reg <= ESC_LEN)
        else $error("escape count out of range");
    a_res_needs_take : assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> take)
        else $error("answer without a consumed beat");
    a_quiet_after_answer : assert property (@(posedge clk) disable iff (!rst_n)
        (take && !op.first && finished_reg) |-> !res_push)
        else $error("answer after walk finished");
    a_finish_on_answer : assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> finished_reg)
        else $error("walk not finished after answer");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pc_line_delta_table_query_core.sv -----
// Top level of the pc/line delta table query core: configuration registers and queues.
// Depends on pltq_pkg, pltq_front, pltq_back, pltq_fifo.
//
// Feed the table one byte per beat, the first beat flagged first_of_table and the last
// flagged last_of_table; each walk yields at most one result beat (stack offset or line
// at query_pc, or the address nearest query_line). The core sustains one table byte per
// clock: the back end retires one decoded byte per cycle through a single pc/value update
// with its compares, and the front end decodes the pc and value steps as the byte is
// pushed. The back end takes a byte at the earliest at the clock edge after it is pushed,
// and a result that byte causes shows on the result port right after that same edge. The
// back end holds while the result queue is full, so a stalled reader stalls the input
// once the queue between decode and walk fills. MID_DEPTH sets that queue, OUT_DEPTH the
// result queue. Write configuration only while the core is idle.
`default_nettype none

module pc_line_delta_table_query_core
    import pltq_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire item_t       item,
    output logic             empty,
    input  wire logic        pop,
    output result_t          result,
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    op_t     front_op, back_op;
    logic    op_push, op_full, op_empty, take;
    logic    res_push, res_full;
    result_t back_res;
    logic [$bits(op_t)-1:0]     mid_rd_data;
    logic [$bits(result_t)-1:0] out_rd_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_QUERY_MODE: cfg_next.query_mode = cfg_data[1:0];
                CFG_TEXT_START: cfg_next.text_start = cfg_data;
                CFG_TEXT_END:   cfg_next.text_end   = cfg_data;
                CFG_PC_QUANTUM: cfg_next.pc_quantum = cfg_data[4:0];
                CFG_QUERY_PC:   cfg_next.query_pc   = cfg_data;
                CFG_QUERY_LINE: cfg_next.query_line = cfg_data;
                CFG_BASE_PC:    cfg_next.base_pc    = cfg_data;
                CFG_END_PC:     cfg_next.end_pc     = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.query_mode <= MODE_LINE;
            cfg_reg.text_start <= '0;
            cfg_reg.text_end   <= '0;
            cfg_reg.pc_quantum <= 5'd1;
            cfg_reg.query_pc   <= '0;
            cfg_reg.query_line <= '0;
            cfg_reg.base_pc    <= '0;
            cfg_reg.end_pc     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pltq_front u_front (
        .push    (push),
        .full    (full),
        .item    (item),
        .cfg     (cfg_reg),
        .op_push (op_push),
        .op      (front_op),
        .op_full (op_full)
    );

    pltq_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_push),
        .wr_data (front_op),
        .full    (op_full),
        .rd_en   (take),
        .rd_data (mid_rd_data),
        .empty   (op_empty)
    );

    assign back_op = op_t'(mid_rd_data);

    pltq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op       (back_op),
        .op_empty (op_empty),
        .take     (take),
        .res_full (res_full),
        .res_push (res_push),
        .res      (back_res)
    );

    pltq_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop && !empty),
        .rd_data (out_rd_data),
        .empty   (empty)
    );

    assign result = result_t'(out_rd_data);

endmodule

`default_nettype wire
